### sv/shuffled_lehmer_random_generator_assert.svh
// Assertion macros for the shuffled Lehmer random generator
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_ASSERT_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SLRG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLRG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/slrg_pkg.sv
`timescale 1ns / 1ps

package slrg_pkg;

   localparam logic [30:0] LEH_MOD      = 31'h7FFF_FFFF;
   localparam logic [14:0] LEH_MULT     = 15'd16807;
   localparam int          WARMUP_STEPS = 8;

   typedef logic [3:0] pc_type;

   localparam pc_type STEP_DISPATCH  = 4'd0;
   localparam pc_type STEP_SEED      = 4'd1;
   localparam pc_type STEP_WARM_MUL  = 4'd2;
   localparam pc_type STEP_WARM_FOLD = 4'd3;
   localparam pc_type STEP_FILL_INIT = 4'd4;
   localparam pc_type STEP_FILL_MUL  = 4'd5;
   localparam pc_type STEP_FILL_FOLD = 4'd6;
   localparam pc_type STEP_DRAW_MUL  = 4'd7;
   localparam pc_type STEP_DRAW_FOLD = 4'd8;
   localparam pc_type STEP_DRAW_READ = 4'd9;
   localparam pc_type STEP_DRAW_SWAP = 4'd10;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_LOOP,
      JMP_DRAW
   } jmp_type;

   typedef struct packed {
      logic    ld_seed;
      logic    ld_cnt_warm;
      logic    ld_cnt_fill;
      logic    dec_cnt;
      logic    mul_x;
      logic    fold_x;
      logic    fill_wr;
      logic    q_mul;
      logic    slot_calc;
      logic    mem_rd;
      logic    swap;
      logic    done;
      jmp_type jmp;
      pc_type  target;
   } ctl_word_type;

   typedef struct packed {
      logic cnt_last;
      logic need_seed;
   } status_type;

   function automatic ctl_word_type ucode_word(input pc_type pc);
      ctl_word_type w;
      w = '0;
      w.jmp = JMP_NEXT;
      w.target = STEP_DISPATCH;
      case (pc)
         STEP_DISPATCH: begin
            w.jmp = JMP_DRAW;
            w.target = STEP_DRAW_MUL;
         end
         STEP_SEED: begin
            w.ld_seed = 1'b1;
            w.ld_cnt_warm = 1'b1;
         end
         STEP_WARM_MUL: begin
            w.mul_x = 1'b1;
         end
         STEP_WARM_FOLD: begin
            w.fold_x = 1'b1;
            w.dec_cnt = 1'b1;
            w.jmp = JMP_LOOP;
            w.target = STEP_WARM_MUL;
         end
         STEP_FILL_INIT: begin
            w.ld_cnt_fill = 1'b1;
         end
         STEP_FILL_MUL: begin
            w.mul_x = 1'b1;
         end
         STEP_FILL_FOLD: begin
            w.fold_x = 1'b1;
            w.dec_cnt = 1'b1;
            w.fill_wr = 1'b1;
            w.jmp = JMP_LOOP;
            w.target = STEP_FILL_MUL;
         end
         STEP_DRAW_MUL: begin
            w.mul_x = 1'b1;
            w.q_mul = 1'b1;
         end
         STEP_DRAW_FOLD: begin
            w.fold_x = 1'b1;
            w.slot_calc = 1'b1;
         end
         STEP_DRAW_READ: begin
            w.mem_rd = 1'b1;
         end
         STEP_DRAW_SWAP: begin
            w.swap = 1'b1;
            w.done = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

### sv/slrg_sequencer.sv
`timescale 1ns / 1ps

module slrg_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  slrg_pkg::status_type      status,
   output slrg_pkg::ctl_word_type    ctl,
   output logic                      busy
);
   import slrg_pkg::*;

   pc_type pc_ff, pc_in;
   logic   busy_ff, busy_in;
   logic   taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_DISPATCH;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      ctl = busy_ff ? ucode_word(pc_ff) : '0;
      case (ctl.jmp)
         JMP_LOOP: taken = !status.cnt_last;
         JMP_DRAW: taken = !status.need_seed;
         default:  taken = 1'b0;
      endcase
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (go) begin
            pc_in   = STEP_DISPATCH;
            busy_in = 1'b1;
         end
      end else if (ctl.done) begin
         pc_in   = STEP_DISPATCH;
         busy_in = 1'b0;
      end else begin
         pc_in = taken ? ctl.target : pc_type'(pc_ff + 4'd1);
      end
   end

   assign busy = busy_ff;

endmodule

### sv/shuffled_lehmer_random_generator.sv
`timescale 1ns / 1ps
// Channel   | Ports                                      | Handshake
// ----------+--------------------------------------------+------------------------------
// request   | start, busy, req_mode, req_seed            | taken when start && !busy
// response  | rsp_strobe, rsp_random_value,              | one-cycle strobe, no stall
//           | rsp_generator_value                        |
// A draw steps dispatch, multiply, fold, read, swap; the strobe rises as busy falls.
// A reseed, or a draw before any seeding, adds seed load, warm-up and table fill steps.
// Each Lehmer step takes two microcode steps: constant multiply, then Mersenne fold.
// Reset is synchronous and leaves the block unseeded; the table is not cleared.
// The receiver cannot stall; a new request may be taken in the strobe cycle.

module shuffled_lehmer_random_generator #(
   parameter int TABLE_SIZE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [30:0] req_seed,
   output logic        rsp_strobe,
   output logic [30:0] rsp_random_value,
   output logic [30:0] rsp_generator_value
);
   import slrg_pkg::*;

   localparam int     IDX_W       = $clog2(TABLE_SIZE);
   localparam int     CNT_W       = ($clog2(TABLE_SIZE + 1) > 4) ? $clog2(TABLE_SIZE + 1) : 4;
   localparam longint SLOT_DIV    = 64'd1 + (64'd2147483646 / TABLE_SIZE);
   localparam int     RECIP_SHIFT = 37;
   localparam longint RECIP       = ((64'd1 << RECIP_SHIFT) + SLOT_DIV - 64'd1) / SLOT_DIV;
   localparam int     RECIP_W     = $clog2(RECIP + 1);
   localparam int     QW          = $clog2(TABLE_SIZE + 2);
   localparam int     QP_W        = RECIP_SHIFT + QW + 1;
   localparam int     QC_W        = QW + 31;

   localparam logic [30:0]      SLOT_DIV_V = 31'(SLOT_DIV);
   localparam logic [RECIP_W-1:0] RECIP_V  = RECIP_W'(RECIP);

   function automatic logic [30:0] mod_fold(input logic [45:0] p);
      logic [31:0] r;
      r = {1'b0, p[30:0]} + {17'd0, p[45:31]};
      if (r >= {1'b0, LEH_MOD}) begin
         r = r - {1'b0, LEH_MOD};
      end
      return r[30:0];
   endfunction

   ctl_word_type ctl;
   status_type   status;
   logic         accept;

   logic             mode_ff;
   logic [30:0]      seed_ff;
   logic [30:0]      x_ff, x_in;
   logic [30:0]      last_ff, last_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [45:0]      prod_ff;
   logic [QP_W-1:0]  qprod_ff;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [30:0]      rdata_ff;
   logic             strobe_ff;
   logic [30:0]      rand_ff;
   logic [30:0]      gen_ff;

   logic [30:0]      fold_val;
   logic [30:0]      seed_eff;
   logic [CNT_W-1:0] cnt_m1;
   logic [QW-1:0]    qest;
   logic [QW-1:0]    qcorr;
   logic [QC_W-1:0]  qchk;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [30:0]      wr_data;

   logic [30:0] shuf_mem [TABLE_SIZE];

   assign accept = start && !busy;

   slrg_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .go     (accept),
      .status (status),
      .ctl    (ctl),
      .busy   (busy)
   );

   assign status.cnt_last  = (cnt_ff == CNT_W'(1));
   assign status.need_seed = mode_ff || (last_ff == 31'd0);

   always_comb begin
      fold_val = mod_fold(prod_ff);
      seed_eff = (!mode_ff || seed_ff == 31'd0 || seed_ff == LEH_MOD) ? 31'd1 : seed_ff;
      cnt_m1   = cnt_ff - CNT_W'(1);

      x_in = x_ff;
      if (ctl.ld_seed) begin
         x_in = seed_eff;
      end else if (ctl.fold_x) begin
         x_in = fold_val;
      end

      cnt_in = cnt_ff;
      if (ctl.ld_cnt_warm) begin
         cnt_in = CNT_W'(WARMUP_STEPS);
      end else if (ctl.ld_cnt_fill) begin
         cnt_in = CNT_W'(TABLE_SIZE);
      end else if (ctl.dec_cnt) begin
         cnt_in = cnt_m1;
      end

      last_in = last_ff;
      if (ctl.fill_wr) begin
         last_in = fold_val;
      end else if (ctl.swap) begin
         last_in = rdata_ff;
      end

      qest  = qprod_ff[RECIP_SHIFT +: QW];
      qchk  = QC_W'(qest) * QC_W'(SLOT_DIV_V);
      qcorr = (qchk > QC_W'(last_ff)) ? QW'(qest - QW'(1)) : qest;
      if (qcorr >= QW'(TABLE_SIZE)) begin
         slot_in = IDX_W'(TABLE_SIZE - 1);
      end else begin
         slot_in = qcorr[IDX_W-1:0];
      end

      wr_en   = ctl.fill_wr || ctl.swap;
      wr_addr = ctl.swap ? slot_ff : cnt_m1[IDX_W-1:0];
      wr_data = ctl.swap ? x_ff : fold_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff      <= 31'd1;
         last_ff   <= 31'd0;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         x_ff      <= x_in;
         last_ff   <= last_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= ctl.swap;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         seed_ff <= req_seed;
      end
      if (ctl.mul_x) begin
         prod_ff <= 46'(x_ff) * 46'(LEH_MULT);
      end
      if (ctl.q_mul) begin
         qprod_ff <= QP_W'(last_ff) * QP_W'(RECIP_V);
      end
      if (ctl.slot_calc) begin
         slot_ff <= slot_in;
      end
      if (ctl.swap) begin
         rand_ff <= rdata_ff;
         gen_ff  <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         shuf_mem[wr_addr] <= wr_data;
      end
      if (ctl.mem_rd) begin
         rdata_ff <= shuf_mem[slot_ff];
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_random_value    = rand_ff;
   assign rsp_generator_value = gen_ff;

endmodule

### sv/slrg_checker.sv
`timescale 1ns / 1ps
`include "shuffled_lehmer_random_generator_assert.svh"

module slrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [30:0] rsp_random_value,
   input logic [30:0] rsp_generator_value
);

   logic values_ok;

   assign values_ok = (rsp_random_value != 31'd0) && (rsp_random_value != 31'h7FFFFFFF)
                      && (rsp_generator_value != 31'd0)
                      && (rsp_generator_value != 31'h7FFFFFFF);

   `SLRG_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request not taken")
   `SLRG_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy, "strobe while busy")
   `SLRG_ASSERT_SAME(a_done_strobe, clock, reset, $fell(busy) && !$past(reset), rsp_strobe, "no response")
   `SLRG_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe, "repeated response")
   `SLRG_ASSERT_SAME(a_value_range, clock, reset, rsp_strobe, values_ok, "value out of range")

endmodule

bind shuffled_lehmer_random_generator slrg_checker u_slrg_checker (.*);
